@@ hdl/lrupr_pkg.sv @@
package lrupr_pkg;

  localparam int unsigned FRAMES    = 16;
  localparam int unsigned PAGE_BITS = 16;

  localparam int unsigned PAGE_W = 16;
  localparam int unsigned KEY_W  = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
  localparam int unsigned IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CNT_W  = $clog2(FRAMES + 1);
  localparam int unsigned FAULT_W = 32;

  localparam int unsigned CFG_W   = 5;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [CFG_W-1:0] CFG_FRAMES_RESET = 5'd16;

  typedef enum logic {
    REG_FRAMES_IN_USE = 1'b0,
    REG_NONE          = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic             start;
    logic             eval;
    logic [IDX_W-1:0] idx;
  } scan_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] hit_rank;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             old_found;
    logic [IDX_W-1:0] old_idx;
    logic [IDX_W-1:0] old_rank;
    logic [KEY_W-1:0] old_page;
  } scan_res_t;

endpackage

@@ hdl/lrupr_if.sv @@
interface lrupr_in_if;
  import lrupr_pkg::*;
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page_number;
  logic              sequence_end;

  modport source (output valid, output page_number, output sequence_end, input ready);
  modport sink (input valid, input page_number, input sequence_end, output ready);
endinterface

interface lrupr_out_if;
  import lrupr_pkg::*;
  logic               valid;
  logic               ready;
  logic               page_fault;
  logic               evicted_valid;
  logic [PAGE_W-1:0]  evicted_page;
  logic [FAULT_W-1:0] fault_total;

  modport source (output valid, output page_fault, output evicted_valid,
                  output evicted_page, output fault_total, input ready);
  modport sink (input valid, input page_fault, input evicted_valid,
                input evicted_page, input fault_total, output ready);
endinterface

@@ hdl/lrupr_ram.sv @@
module lrupr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ hdl/lrupr_cfg.sv @@
module lrupr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lrupr_pkg::PADDR_W-1:0] paddr,
  input  logic [lrupr_pkg::PDATA_W-1:0] pwdata,
  output logic [lrupr_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  output logic [lrupr_pkg::CFG_W-1:0]   frames_in_use_o
);
  import lrupr_pkg::*;

  logic [CFG_W-1:0] frames_q, frames_d;
  reg_idx_e         reg_idx;

  assign pready          = 1'b1;
  assign frames_in_use_o = frames_q;
  assign reg_idx         = reg_idx_e'(paddr[PADDR_W-1]);

  always_comb begin
    frames_d = frames_q;
    if (psel && penable && pwrite && pready && reg_idx == REG_FRAMES_IN_USE) begin
      frames_d = pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAMES_IN_USE: prdata = PDATA_W'(frames_q);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= CFG_FRAMES_RESET;
    end else begin
      frames_q <= frames_d;
    end
  end

endmodule

@@ hdl/lrupr_scan.sv @@
module lrupr_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lrupr_pkg::scan_ctl_t          ctl_i,
  input  logic                          ent_valid_i,
  input  logic [lrupr_pkg::IDX_W-1:0]   ent_rank_i,
  input  logic [lrupr_pkg::KEY_W-1:0]   ent_page_i,
  input  logic [lrupr_pkg::KEY_W-1:0]   key_i,
  output lrupr_pkg::scan_res_t          res_o
);
  import lrupr_pkg::*;

  scan_res_t res_q, res_d;
  logic      page_eq;
  logic      rank_gt;

  assign res_o   = res_q;
  assign page_eq = (ent_page_i == key_i);
  assign rank_gt = (ent_rank_i > res_q.old_rank);

  always_comb begin
    res_d = res_q;
    if (ctl_i.start) begin
      res_d = '0;
    end else if (ctl_i.eval) begin
      if (ent_valid_i) begin
        res_d.count = res_q.count + CNT_W'(1);
        if (!res_q.hit && page_eq) begin
          res_d.hit      = 1'b1;
          res_d.hit_idx  = ctl_i.idx;
          res_d.hit_rank = ent_rank_i;
        end
        if (!res_q.old_found || rank_gt) begin
          res_d.old_found = 1'b1;
          res_d.old_idx   = ctl_i.idx;
          res_d.old_rank  = ent_rank_i;
          res_d.old_page  = ent_page_i;
        end
      end else if (!res_q.free_found) begin
        res_d.free_found = 1'b1;
        res_d.free_idx   = ctl_i.idx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

endmodule

@@ hdl/lru_page_replacement.sv @@
// flow: each accepted word is scanned serially over the frame table through one
//   compare unit and one page store read port, then the table is updated and the
//   result registered; a new word is taken only after that result has been issued
// reset: frame valid bits, recency ranks and fault count clear, frame limit goes to 16;
//   the page store is not cleared, no clearing pass is needed
module lru_page_replacement (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lrupr_pkg::PADDR_W-1:0] paddr,
  input  logic [lrupr_pkg::PDATA_W-1:0] pwdata,
  output logic [lrupr_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  lrupr_in_if.sink                      in_i,
  lrupr_out_if.source                   out_o
);
  import lrupr_pkg::*;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [KEY_W-1:0]   key_q;
  logic               last_q;
  logic [CNT_W-1:0]   lim_q, lim;
  logic [CFG_W-1:0]   frames_in_use;

  logic [FRAMES-1:0]  valid_q, valid_d;
  logic [IDX_W-1:0]   rank_q [FRAMES];
  logic [IDX_W-1:0]   rank_d [FRAMES];
  logic [FAULT_W-1:0] fault_q, fault_d, fault_next;

  logic               out_valid_q;
  logic               fault_r, ev_valid_r;
  logic [PAGE_W-1:0]  ev_page_r;
  logic [FAULT_W-1:0] total_r;

  scan_ctl_t          scan_ctl;
  scan_res_t          res;
  logic [KEY_W-1:0]   rd_page;
  logic               rd_en;
  logic               accept;
  logic               upd_go;
  logic               evict;
  logic [IDX_W-1:0]   slot;

  lrupr_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .frames_in_use_o (frames_in_use)
  );

  lrupr_ram #(
    .WIDTH (KEY_W),
    .DEPTH (FRAMES)
  ) u_page_ram (
    .clk_i,
    .we_i    (upd_go && !res.hit),
    .waddr_i (slot),
    .wdata_i (key_q),
    .re_i    (rd_en),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (rd_page)
  );

  lrupr_scan u_scan (
    .clk_i,
    .rst_ni,
    .ctl_i       (scan_ctl),
    .ent_valid_i (valid_q[scan_ctl.idx]),
    .ent_rank_i  (rank_q[scan_ctl.idx]),
    .ent_page_i  (rd_page),
    .key_i       (key_q),
    .res_o       (res)
  );

  assign in_i.ready          = (state_q == ST_IDLE);
  assign accept              = in_i.valid && in_i.ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.page_fault    = fault_r;
  assign out_o.evicted_valid = ev_valid_r;
  assign out_o.evicted_page  = ev_page_r;
  assign out_o.fault_total   = total_r;

  // effective frame limit
  always_comb begin
    if (frames_in_use == '0) begin
      lim = CNT_W'(1);
    end else if (32'(frames_in_use) > FRAMES) begin
      lim = CNT_W'(FRAMES);
    end else begin
      lim = CNT_W'(frames_in_use);
    end
  end

  // sequencer
  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    scan_ctl.start = 1'b0;
    scan_ctl.eval  = 1'b0;
    scan_ctl.idx   = IDX_W'(cnt_q - CNT_W'(1));
    rd_en          = 1'b0;
    upd_go         = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          scan_ctl.start = 1'b1;
          cnt_d          = '0;
          state_d        = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en         = (32'(cnt_q) < FRAMES);
        scan_ctl.eval = (cnt_q != '0);
        if (cnt_q == CNT_W'(FRAMES)) begin
          state_d = ST_UPDATE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_UPDATE: begin
        if (!out_valid_q || out_o.ready) begin
          upd_go  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // table update
  always_comb begin
    evict      = !res.hit && (res.count >= lim_q);
    slot       = res.hit ? res.hit_idx : (evict ? res.old_idx : res.free_idx);
    fault_next = (res.hit || fault_q == '1) ? fault_q : fault_q + FAULT_W'(1);
    valid_d    = valid_q;
    fault_d    = fault_q;
    for (int j = 0; j < FRAMES; j++) begin
      rank_d[j] = rank_q[j];
    end
    if (upd_go) begin
      fault_d = fault_next;
      for (int j = 0; j < FRAMES; j++) begin
        if (res.hit) begin
          if (valid_q[j] && rank_q[j] < res.hit_rank) begin
            rank_d[j] = rank_q[j] + IDX_W'(1);
          end
        end else if (valid_q[j] && slot != IDX_W'(j)) begin
          rank_d[j] = rank_q[j] + IDX_W'(1);
        end
        if (slot == IDX_W'(j)) begin
          valid_d[j] = 1'b1;
          rank_d[j]  = '0;
        end
        if (last_q) begin
          valid_d[j] = 1'b0;
          rank_d[j]  = '0;
        end
      end
      if (last_q) begin
        fault_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      valid_q     <= '0;
      fault_q     <= '0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < FRAMES; j++) begin
        rank_q[j] <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
      fault_q <= fault_d;
      for (int j = 0; j < FRAMES; j++) begin
        rank_q[j] <= rank_d[j];
      end
      if (upd_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q  <= in_i.page_number[KEY_W-1:0];
      last_q <= in_i.sequence_end;
      lim_q  <= lim;
    end
    if (upd_go) begin
      fault_r    <= !res.hit;
      ev_valid_r <= evict;
      ev_page_r  <= evict ? PAGE_W'(res.old_page) : '0;
      total_r    <= fault_next;
    end
  end

`ifndef SYNTH
  a_result_follows_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_go |=> out_o.valid)
    else $error("result word missing after table update");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SCAN) && (cnt_q == '0))
    else $error("scan did not start after accepted word");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_go && res.hit) |=> (!out_o.evicted_valid && !out_o.page_fault))
    else $error("hit reported a fault or an eviction");

  a_evict_has_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_go && evict) |-> res.old_found)
    else $error("eviction without a valid victim frame");
`endif

endmodule
